>>> rtl/bzf_pkg.sv
`timescale 1ns / 1ps
package bzf_pkg;

    localparam int COORD_W   = 32;
    localparam int WIDTH_W   = 24;
    localparam int S_TDATA_W = 8 * COORD_W;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 4 * COORD_W + WIDTH_W;
    localparam int M_TUSER_W = 2;

    // register stages through the point evaluator
    localparam int EVAL_LAT = 5;

    localparam logic [WIDTH_W-1:0] CURVE_WIDTH_RST = 24'd250000;
    localparam logic [WIDTH_W-1:0] GUIDE_WIDTH     = 24'd1;
    localparam logic [WIDTH_W-1:0] ERROR_WIDTH     = 24'd0;

    typedef logic signed [COORD_W-1:0] coord_t;

    // classified cord description, as queued between front and back
    typedef struct packed {
        logic   err;
        logic   guide1;
        logic   guide2;
        logic   curve;
        coord_t e1x;
        coord_t e1y;
        coord_t e2x;
        coord_t e2y;
        coord_t c1x;
        coord_t c1y;
        coord_t c2x;
        coord_t c2y;
    } desc_t;

    typedef enum logic [1:0] {
        OP_GUIDE,
        OP_LINE,
        OP_CURVE,
        OP_ERROR
    } op_kind_t;

    // one result in flight through the back end
    typedef struct packed {
        op_kind_t kind;
        logic     last;
        logic     first;
        coord_t   sx;
        coord_t   sy;
        coord_t   ex;
        coord_t   ey;
    } op_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_ERROR,
        SEQ_GUIDE1,
        SEQ_GUIDE2,
        SEQ_LINE,
        SEQ_CURVE
    } seq_state_t;

    // Bernstein weight of control point i at step k out of s, scaled by s^3
    function automatic longint bzf_weight(input int s, input int k, input int i);
        longint jj;
        longint kk;
        longint w;
        jj = longint'(s - k);
        kk = longint'(k);
        case (i)
            0:       w = jj * jj * jj;
            1:       w = 3 * jj * jj * kk;
            2:       w = 3 * jj * kk * kk;
            default: w = kk * kk * kk;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/bzf_front.sv
`timescale 1ns / 1ps
module bzf_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // end1_x, end1_y, end2_x, end2_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
    input  logic [bzf_pkg::S_TDATA_W-1:0] s_tdata,
    // has_ctrl1, has_ctrl2, ends_present
    input  logic [bzf_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           q_valid,
    input  logic                           q_ready,
    output bzf_pkg::desc_t                 q_desc
);
    import bzf_pkg::*;

    logic has1;
    logic has2;
    logic ends;

    assign has1 = s_tuser[0];
    assign has2 = s_tuser[1];
    assign ends = s_tuser[2];

    // take a word whenever the queue has room
    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;

    // unpack the coordinates and decide which results the word asks for
    always_comb begin
        q_desc.e1x    = s_tdata[0*COORD_W +: COORD_W];
        q_desc.e1y    = s_tdata[1*COORD_W +: COORD_W];
        q_desc.e2x    = s_tdata[2*COORD_W +: COORD_W];
        q_desc.e2y    = s_tdata[3*COORD_W +: COORD_W];
        q_desc.c1x    = s_tdata[4*COORD_W +: COORD_W];
        q_desc.c1y    = s_tdata[5*COORD_W +: COORD_W];
        q_desc.c2x    = s_tdata[6*COORD_W +: COORD_W];
        q_desc.c2y    = s_tdata[7*COORD_W +: COORD_W];
        q_desc.err    = !ends;
        q_desc.guide1 = ends && has1;
        q_desc.guide2 = ends && has2;
        q_desc.curve  = ends && has1 && has2;
    end

endmodule

>>> rtl/bzf_queue.sv
`timescale 1ns / 1ps
module bzf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  bzf_pkg::desc_t in_desc,
    output logic           out_valid,
    input  logic           out_ready,
    output bzf_pkg::desc_t out_desc
);
    import bzf_pkg::*;

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    desc_t         slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   cnt_reg;
    logic          push;
    logic          pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_desc  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // hold the descriptors
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_desc;
        end
    end

endmodule

>>> rtl/bzf_eval.sv
`timescale 1ns / 1ps
module bzf_eval #(
    parameter int  SEGMENTS = 25,
    localparam int WW       = $clog2(SEGMENTS * SEGMENTS * SEGMENTS + 1)
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [WW-1:0]   w0,
    input  logic [WW-1:0]   w1,
    input  logic [WW-1:0]   w2,
    input  logic [WW-1:0]   w3,
    input  bzf_pkg::coord_t p0,
    input  bzf_pkg::coord_t p1,
    input  bzf_pkg::coord_t p2,
    input  bzf_pkg::coord_t p3,
    output bzf_pkg::coord_t res
);
    import bzf_pkg::*;

    localparam int S3   = SEGMENTS * SEGMENTS * SEGMENTS;
    localparam int PRW  = WW + COORD_W + 1;
    localparam int NW   = PRW + 2;
    localparam int MW   = NW + 1;
    localparam int DEN  = 2 * S3;
    localparam int L    = MW + $clog2(DEN);
    localparam int RW   = MW + 1;
    localparam int H    = (RW + 1) / 2;
    localparam int MHW  = MW - H;
    localparam int RHW  = RW - H;
    localparam int PW   = MW + RW;
    localparam logic [127:0] DEN_W = 128'(DEN);
    localparam logic [127:0] RCP_W = ((128'd1 << L) + DEN_W - 128'd1) / DEN_W;
    localparam logic [RW-1:0] RCP    = RCP_W[RW-1:0];
    localparam logic [H-1:0]  RCP_LO = RCP[H-1:0];
    localparam logic [RHW-1:0] RCP_HI = RCP[RW-1:H];
    localparam logic [MW-1:0] HALF   = MW'(S3);

    logic signed [PRW-1:0] pr_reg [4];
    logic signed [NW-1:0]  sum_reg;
    logic [NW-1:0]         mag;
    logic [MW-1:0]         m_reg;
    logic                  neg3_reg;
    logic                  neg4_reg;
    logic                  neg5_reg;
    logic [2*H-1:0]        pp_ll_reg;
    logic [H+RHW-1:0]      pp_lh_reg;
    logic [MHW+H-1:0]      pp_hl_reg;
    logic [MHW+RHW-1:0]    pp_hh_reg;
    logic [PW-1:0]         total;
    logic [COORD_W-1:0]    q_reg;

    // weight each point
    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg[0] <= $signed({1'b0, w0}) * p0;
            pr_reg[1] <= $signed({1'b0, w1}) * p1;
            pr_reg[2] <= $signed({1'b0, w2}) * p2;
            pr_reg[3] <= $signed({1'b0, w3}) * p3;
        end
    end

    // sum the weighted points into the exact numerator
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= NW'(pr_reg[0]) + NW'(pr_reg[1]) + NW'(pr_reg[2]) + NW'(pr_reg[3]);
        end
    end

    // fold the sign out and add half the divisor for rounding
    assign mag = sum_reg[NW-1] ? NW'(-sum_reg) : NW'(sum_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            neg3_reg <= sum_reg[NW-1];
            m_reg    <= MW'({mag, 1'b0}) + HALF;
        end
    end

    // partial products of the reciprocal multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            neg4_reg  <= neg3_reg;
            pp_ll_reg <= m_reg[H-1:0] * RCP_LO;
            pp_lh_reg <= m_reg[H-1:0] * RCP_HI;
            pp_hl_reg <= m_reg[MW-1:H] * RCP_LO;
            pp_hh_reg <= m_reg[MW-1:H] * RCP_HI;
        end
    end

    // combine and drop the fraction bits
    assign total = (PW'(pp_hh_reg) << (2 * H)) + (PW'(pp_lh_reg) << H)
                 + (PW'(pp_hl_reg) << H) + PW'(pp_ll_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            neg5_reg <= neg4_reg;
            q_reg    <= total[L +: COORD_W];
        end
    end

    // restore the sign
    assign res = neg5_reg ? coord_t'(-q_reg) : coord_t'(q_reg);

endmodule

>>> rtl/bzf_back.sv
`timescale 1ns / 1ps
module bzf_back #(
    parameter int SEGMENTS = 25
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  bzf_pkg::desc_t                 q_desc,
    input  logic [bzf_pkg::WIDTH_W-1:0]   curve_width,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bzf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [bzf_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import bzf_pkg::*;

    localparam int KW = $clog2(SEGMENTS + 1);
    localparam int S3 = SEGMENTS * SEGMENTS * SEGMENTS;
    localparam int WW = $clog2(S3 + 1);
    localparam logic [KW-1:0] K_FIRST = KW'(1);
    localparam logic [KW-1:0] K_LAST  = KW'(SEGMENTS);

    logic [WW-1:0] w0_tab [SEGMENTS+1];
    logic [WW-1:0] w1_tab [SEGMENTS+1];
    logic [WW-1:0] w2_tab [SEGMENTS+1];
    logic [WW-1:0] w3_tab [SEGMENTS+1];

    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [KW-1:0]       k_reg;
    logic [KW-1:0]       k_next;
    desc_t               cur_reg;
    logic                adv;
    logic                iss_vld;
    op_t                 iss_op;
    logic [EVAL_LAT-1:0] pipe_vld_reg;
    op_t                 pipe_op_reg [EVAL_LAT];
    op_t                 tail_op;
    logic                tail_vld;
    coord_t              res_x;
    coord_t              res_y;

    logic               out_vld_reg;
    logic               out_edit_reg;
    logic               out_edit_next;
    logic               out_err_reg;
    logic               out_err_next;
    logic               out_last_reg;
    logic               out_last_next;
    coord_t             out_sx_reg;
    coord_t             out_sx_next;
    coord_t             out_sy_reg;
    coord_t             out_sy_next;
    coord_t             out_ex_reg;
    coord_t             out_ex_next;
    coord_t             out_ey_reg;
    coord_t             out_ey_next;
    logic [WIDTH_W-1:0] out_w_reg;
    logic [WIDTH_W-1:0] out_w_next;
    coord_t             lx_reg;
    coord_t             ly_reg;

    // Bernstein weight table, one row per step
    for (genvar g = 0; g <= SEGMENTS; g++) begin : g_wtab
        assign w0_tab[g] = WW'(bzf_weight(SEGMENTS, g, 0));
        assign w1_tab[g] = WW'(bzf_weight(SEGMENTS, g, 1));
        assign w2_tab[g] = WW'(bzf_weight(SEGMENTS, g, 2));
        assign w3_tab[g] = WW'(bzf_weight(SEGMENTS, g, 3));
    end

    // the whole back end moves when the output register can take a word
    assign adv = !out_vld_reg || m_tready;

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            k_reg     <= K_FIRST;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == SEQ_IDLE && q_valid) begin
            cur_reg <= q_desc;
        end
    end

    // issue one result per cycle for the current cord while the back end can advance
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        q_ready      = 1'b0;
        iss_vld      = 1'b0;
        iss_op.kind  = OP_LINE;
        iss_op.last  = 1'b0;
        iss_op.first = (k_reg == K_FIRST);
        iss_op.sx    = cur_reg.e1x;
        iss_op.sy    = cur_reg.e1y;
        iss_op.ex    = cur_reg.e2x;
        iss_op.ey    = cur_reg.e2y;
        case (state_reg)
            SEQ_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    k_next = K_FIRST;
                    if (q_desc.err) begin
                        state_next = SEQ_ERROR;
                    end else if (q_desc.guide1) begin
                        state_next = SEQ_GUIDE1;
                    end else if (q_desc.guide2) begin
                        state_next = SEQ_GUIDE2;
                    end else begin
                        state_next = SEQ_LINE;
                    end
                end
            end
            SEQ_ERROR: begin
                iss_vld     = 1'b1;
                iss_op.kind = OP_ERROR;
                iss_op.last = 1'b1;
                if (adv) begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_GUIDE1: begin
                iss_vld     = 1'b1;
                iss_op.kind = OP_GUIDE;
                iss_op.ex   = cur_reg.c1x;
                iss_op.ey   = cur_reg.c1y;
                if (adv) begin
                    if (cur_reg.guide2) begin
                        state_next = SEQ_GUIDE2;
                    end else begin
                        state_next = SEQ_LINE;
                    end
                end
            end
            SEQ_GUIDE2: begin
                iss_vld     = 1'b1;
                iss_op.kind = OP_GUIDE;
                iss_op.sx   = cur_reg.e2x;
                iss_op.sy   = cur_reg.e2y;
                iss_op.ex   = cur_reg.c2x;
                iss_op.ey   = cur_reg.c2y;
                if (adv) begin
                    if (cur_reg.curve) begin
                        state_next = SEQ_CURVE;
                    end else begin
                        state_next = SEQ_LINE;
                    end
                end
            end
            SEQ_LINE: begin
                iss_vld     = 1'b1;
                iss_op.last = 1'b1;
                if (adv) begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_CURVE: begin
                iss_vld     = 1'b1;
                iss_op.kind = OP_CURVE;
                iss_op.last = (k_reg == K_LAST);
                if (adv) begin
                    if (k_reg == K_LAST) begin
                        state_next = SEQ_IDLE;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // curve point for the current step, both axes
    bzf_eval #(
        .SEGMENTS(SEGMENTS)
    ) u_eval_x (
        .aclk (aclk),
        .en   (adv),
        .w0   (w0_tab[k_reg]),
        .w1   (w1_tab[k_reg]),
        .w2   (w2_tab[k_reg]),
        .w3   (w3_tab[k_reg]),
        .p0   (cur_reg.e1x),
        .p1   (cur_reg.c1x),
        .p2   (cur_reg.c2x),
        .p3   (cur_reg.e2x),
        .res  (res_x)
    );

    bzf_eval #(
        .SEGMENTS(SEGMENTS)
    ) u_eval_y (
        .aclk (aclk),
        .en   (adv),
        .w0   (w0_tab[k_reg]),
        .w1   (w1_tab[k_reg]),
        .w2   (w2_tab[k_reg]),
        .w3   (w3_tab[k_reg]),
        .p0   (cur_reg.e1y),
        .p1   (cur_reg.c1y),
        .p2   (cur_reg.c2y),
        .p3   (cur_reg.e2y),
        .res  (res_y)
    );

    // carry each result's description alongside the evaluator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_vld_reg <= '0;
        end else if (adv) begin
            pipe_vld_reg <= {pipe_vld_reg[EVAL_LAT-2:0], iss_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_op_reg[0] <= iss_op;
            for (int i = 1; i < EVAL_LAT; i++) begin
                pipe_op_reg[i] <= pipe_op_reg[i-1];
            end
        end
    end

    assign tail_op  = pipe_op_reg[EVAL_LAT-1];
    assign tail_vld = pipe_vld_reg[EVAL_LAT-1];

    // build the outgoing word
    always_comb begin
        out_edit_next = 1'b0;
        out_err_next  = 1'b0;
        out_last_next = tail_op.last;
        out_sx_next   = tail_op.sx;
        out_sy_next   = tail_op.sy;
        out_ex_next   = tail_op.ex;
        out_ey_next   = tail_op.ey;
        out_w_next    = curve_width;
        case (tail_op.kind)
            OP_GUIDE: begin
                out_edit_next = 1'b1;
                out_w_next    = GUIDE_WIDTH;
            end
            OP_LINE: begin
                out_w_next = curve_width;
            end
            OP_CURVE: begin
                if (!tail_op.first) begin
                    out_sx_next = lx_reg;
                    out_sy_next = ly_reg;
                end
                out_ex_next = res_x;
                out_ey_next = res_y;
            end
            OP_ERROR: begin
                out_err_next = 1'b1;
                out_sx_next  = '0;
                out_sy_next  = '0;
                out_ex_next  = '0;
                out_ey_next  = '0;
                out_w_next   = ERROR_WIDTH;
            end
            default: begin
                out_err_next = 1'b1;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= tail_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tail_vld) begin
            out_edit_reg <= out_edit_next;
            out_err_reg  <= out_err_next;
            out_last_reg <= out_last_next;
            out_sx_reg   <= out_sx_next;
            out_sy_reg   <= out_sy_next;
            out_ex_reg   <= out_ex_next;
            out_ey_reg   <= out_ey_next;
            out_w_reg    <= out_w_next;
            // remember the curve point as the next segment's start
            if (tail_op.kind == OP_CURVE) begin
                lx_reg <= res_x;
                ly_reg <= res_y;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_w_reg, out_ey_reg, out_ex_reg, out_sy_reg, out_sx_reg};
    assign m_tuser  = {out_err_reg, out_edit_reg};
    assign m_tlast  = out_last_reg;

    a_error_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_err_reg |-> out_last_reg && !out_edit_reg && out_w_reg == ERROR_WIDTH)
        else $error("error word not alone or carries geometry");

    a_guide_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_edit_reg |-> !out_last_reg && out_w_reg == GUIDE_WIDTH)
        else $error("guide word closes a cord or has wrong width");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == SEQ_CURVE |-> k_reg != '0 && k_reg <= K_LAST)
        else $error("curve step out of range");

    a_curve_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == SEQ_CURVE && k_reg == K_LAST && adv |=> state_reg == SEQ_IDLE)
        else $error("sequencer did not leave the curve after its final step");

endmodule

>>> rtl/cubic_bezier_flattener_core.sv
`timescale 1ns / 1ps
// Cubic Bezier cord flattener. Each input word carries two end points, two
// control points and presence flags; the block returns one error word when an
// end is missing, else a guide segment per present control point followed by
// SEGMENTS curve segments (both controls present) or one straight segment.
// Curve points are rounded to nearest, halves away from zero, and the last
// segment ends exactly on end 2. Input words go through a two-deep descriptor
// queue, so the next cord is taken while the current one is still being
// produced. The back-end sequencer loads each cord in its idle state, then
// issues one result per cycle while the output register is not stalled. Each
// result passes through the fixed-point point evaluator and the output register.
// curve_width may be written only while the block is idle.
module cubic_bezier_flattener_core #(
    parameter int SEGMENTS = 25
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // end1_x, end1_y, end2_x, end2_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
    input  logic [bzf_pkg::S_TDATA_W-1:0] s_tdata,
    // has_ctrl1, has_ctrl2, ends_present
    input  logic [bzf_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // start_x, start_y, stop_x, stop_y, line_width
    output logic [bzf_pkg::M_TDATA_W-1:0] m_tdata,
    // on_edit_layer, error
    output logic [bzf_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    // curve_width
    input  logic [bzf_pkg::WIDTH_W-1:0]   cfg_data
);
    import bzf_pkg::*;

    logic               fq_valid;
    logic               fq_ready;
    desc_t              fq_desc;
    logic               qb_valid;
    logic               qb_ready;
    desc_t              qb_desc;
    logic [WIDTH_W-1:0] curve_width_reg;

    // width register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_width_reg <= CURVE_WIDTH_RST;
        end else if (cfg_valid && cfg_ready) begin
            curve_width_reg <= cfg_data;
        end
    end

    bzf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_desc   (fq_desc)
    );

    bzf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_desc   (fq_desc),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_desc  (qb_desc)
    );

    bzf_back #(
        .SEGMENTS(SEGMENTS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_desc      (qb_desc),
        .curve_width (curve_width_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
